FILE: rtl/kwm_pkg.sv
package kwm_pkg;

    localparam int HIST_DEPTH = 11;
    localparam int WIN_LEN    = HIST_DEPTH + 1;
    localparam int KW_COUNT   = 17;
    localparam int KW_BITS    = 8 * WIN_LEN;

    typedef logic [7:0] txt_byte_t;

    typedef enum logic [1:0] {
        SEV_LOW      = 2'd0,
        SEV_MEDIUM   = 2'd1,
        SEV_HIGH     = 2'd2,
        SEV_CRITICAL = 2'd3
    } sev_t;

    // shift / clear strobe shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // keywords right aligned: bits [7:0] hold the final character
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'("honeytoken"),
        KW_BITS'("credential"),
        KW_BITS'("/etc/passwd"),
        KW_BITS'("..%2f"),
        KW_BITS'("../"),
        KW_BITS'("union select"),
        KW_BITS'(" or 1=1"),
        KW_BITS'("curl "),
        KW_BITS'("wget "),
        KW_BITS'("powershell"),
        KW_BITS'("cmd.exe"),
        KW_BITS'("ssh"),
        KW_BITS'("database"),
        KW_BITS'("mysql"),
        KW_BITS'("admin"),
        KW_BITS'("login"),
        KW_BITS'("api")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        10, 10, 11, 5, 3, 12, 7,
        5, 5, 10, 7, 3, 8, 5,
        5, 5, 3
    };

    localparam sev_t KW_LEVEL [KW_COUNT] = '{
        SEV_CRITICAL, SEV_CRITICAL, SEV_CRITICAL, SEV_CRITICAL,
        SEV_CRITICAL, SEV_CRITICAL, SEV_CRITICAL,
        SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_HIGH, SEV_HIGH,
        SEV_MEDIUM, SEV_MEDIUM, SEV_MEDIUM
    };

    // ascii upper case to lower case, everything else untouched
    function automatic txt_byte_t fold_byte(input txt_byte_t b);
        txt_byte_t r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/kwm_in_if.sv
interface kwm_in_if;
    logic                valid;
    logic                ready;
    kwm_pkg::txt_byte_t  text_byte;
    logic                last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

FILE: rtl/kwm_out_if.sv
interface kwm_out_if;
    logic          valid;
    logic          ready;
    kwm_pkg::sev_t severity;
    logic          alert_flag;

    modport source (output valid, output severity, output alert_flag, input ready);
    modport sink   (input valid, input severity, input alert_flag, output ready);
endinterface

FILE: rtl/kwm_cell.sv
module kwm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  kwm_pkg::cell_ctrl_t ctrl,
    input  kwm_pkg::txt_byte_t  shift_in,
    output kwm_pkg::txt_byte_t  held
);

    kwm_pkg::txt_byte_t byte_reg;
    kwm_pkg::txt_byte_t byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign held = byte_reg;

endmodule

FILE: rtl/kwm_match.sv
module kwm_match (
    input  logic [kwm_pkg::WIN_LEN-1:0][7:0] win,
    output kwm_pkg::sev_t                    level
);

    // win[0] is the current byte, win[i] the byte i places earlier
    always_comb
    begin
        logic hit;
        kwm_pkg::sev_t best;
        best = kwm_pkg::SEV_LOW;
        for (int k = 0; k < kwm_pkg::KW_COUNT; k++)
        begin
            hit = 1'b1;
            for (int i = 0; i < kwm_pkg::WIN_LEN; i++)
            begin
                if (i < kwm_pkg::KW_LEN[k] && win[i] != kwm_pkg::KW_TEXT[k][8*i +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit && kwm_pkg::KW_LEVEL[k] > best)
            begin
                best = kwm_pkg::KW_LEVEL[k];
            end
        end
        level = best;
    end

endmodule

FILE: rtl/keyword_severity_matcher.sv
// keyword_severity_matcher
//
// text_ch (sink) takes one word per clock: text_byte plus last_byte, which
// marks the final byte of an event text (event type, space, payload).
// every byte is folded to lower case (ascii a..z) and compared, together
// with the eleven bytes before it, against seventeen fixed keywords; a hit
// raises a sticky severity (medium, high, critical) held for the text.
// result_ch (source) gives one word per text: severity and alert_flag,
// presented the cycle after the last byte is taken, from an output register.
// bytes that are not last give no word.
// throughput is one byte per clock while text_ch.ready is high; the compare
// of the twelve-byte window against all keywords is combinational, between
// the input handshake and the window cells / severity register.
// text_ch.ready drops only while a result word is held and result_ch.ready
// is low; when the receiver takes the word the next byte is accepted in the
// same cycle.
// reset clears the window cells to zero, severity to low, and empties the
// output register; an accepted last byte clears cells and severity too.
module keyword_severity_matcher (
    input  logic          clk,
    input  logic          rst_n,
    kwm_in_if.sink        text_ch,
    kwm_out_if.source     result_ch
);

    // window cells: hist[0] is the most recent earlier byte
    kwm_pkg::txt_byte_t hist [kwm_pkg::HIST_DEPTH];
    kwm_pkg::txt_byte_t cur_byte;
    kwm_pkg::cell_ctrl_t cell_ctrl;
    logic [kwm_pkg::WIN_LEN-1:0][7:0] win;
    kwm_pkg::sev_t win_level;

    logic in_accept;
    logic out_free;

    kwm_pkg::sev_t sev_reg;
    kwm_pkg::sev_t sev_next;
    kwm_pkg::sev_t sev_max;

    logic          out_valid_reg;
    logic          out_valid_next;
    kwm_pkg::sev_t out_sev_reg;
    logic          out_alert_reg;

    assign out_free         = !out_valid_reg || result_ch.ready;
    assign text_ch.ready    = out_free;
    assign in_accept        = text_ch.valid && out_free;

    assign cur_byte         = kwm_pkg::fold_byte(text_ch.text_byte);
    assign cell_ctrl.shift  = in_accept && !text_ch.last_byte;
    assign cell_ctrl.clear  = in_accept && text_ch.last_byte;

    // chain of window cells, each loading from its neighbor on a shift
    genvar gi;
    generate
        for (gi = 0; gi < kwm_pkg::HIST_DEPTH; gi++)
        begin : g_cell
            kwm_pkg::txt_byte_t from_left;
            if (gi == 0)
            begin : g_head
                assign from_left = cur_byte;
            end
            else
            begin : g_body
                assign from_left = hist[gi-1];
            end
            kwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .shift_in (from_left),
                .held     (hist[gi])
            );
            assign win[gi+1] = hist[gi];
        end
    endgenerate

    assign win[0] = cur_byte;

    kwm_match u_match (
        .win   (win),
        .level (win_level)
    );

    // running severity only rises within a text
    assign sev_max = (win_level > sev_reg) ? win_level : sev_reg;

    always_comb
    begin
        sev_next = sev_reg;
        if (in_accept)
        begin
            sev_next = text_ch.last_byte ? kwm_pkg::SEV_LOW : sev_max;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept && text_ch.last_byte)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sev_reg       <= kwm_pkg::SEV_LOW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sev_reg       <= sev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (in_accept && text_ch.last_byte)
        begin
            out_sev_reg   <= sev_max;
            out_alert_reg <= (sev_max != kwm_pkg::SEV_LOW);
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.severity   = out_sev_reg;
    assign result_ch.alert_flag = out_alert_reg;

    // a result word appears only after a last byte was taken
    a_word_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && text_ch.last_byte))
        else $error("result word without a last byte");

    // a stalled result word blocks the input side
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ch.ready) |-> !text_ch.ready)
        else $error("byte accepted while result word stalled");

    // last byte clears the running severity and the window
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && text_ch.last_byte)
        |=> (sev_reg == kwm_pkg::SEV_LOW && hist[0] == '0
             && hist[kwm_pkg::HIST_DEPTH-1] == '0))
        else $error("state not cleared after last byte");

    // alert flag agrees with the severity carried in the same word
    a_alert_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_alert_reg == (out_sev_reg != kwm_pkg::SEV_LOW)))
        else $error("alert flag disagrees with severity");

    // severity never drops inside a text
    a_sev_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !text_ch.last_byte) |=> (sev_reg >= $past(sev_reg)))
        else $error("running severity decreased");

endmodule

FILE: dv/testbench.sv
module testbench;

    // no word accepted on either side for this many cycles ends the run
    localparam int QUIET_LIMIT = 2000;
    // receiver hold-off long enough to back the block up into the sender
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_ITEMS = 1000;
    // last stretch of the run goes without any idling
    localparam int CALM_FROM   = 900;
    localparam int TAIL_CYCLES = 20;

    // one stimulus row: a text byte, its last mark, and an optional
    // hand-written severity for the text that this row closes
    typedef struct {
        logic [7:0]    text_byte;
        logic          last_byte;
        bit            typed;
        kwm_pkg::sev_t severity;
    } text_row_t;

    // what the result channel should give for one closed text
    typedef struct {
        kwm_pkg::sev_t severity;
        logic          alert_flag;
    } verdict_t;

    logic clk;
    logic rst_n;

    kwm_in_if  text_ch ();
    kwm_out_if result_ch ();

    keyword_severity_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_ch   (text_ch),
        .result_ch (result_ch)
    );

    // keyword list with the level each one raises
    string kw_word [kwm_pkg::KW_COUNT] = '{
        "honeytoken", "credential", "/etc/passwd", "..%2f", "../",
        "union select", " or 1=1",
        "curl ", "wget ", "powershell", "cmd.exe", "ssh", "database", "mysql",
        "admin", "login", "api"
    };
    kwm_pkg::sev_t kw_sev [kwm_pkg::KW_COUNT] = '{
        kwm_pkg::SEV_CRITICAL, kwm_pkg::SEV_CRITICAL, kwm_pkg::SEV_CRITICAL,
        kwm_pkg::SEV_CRITICAL, kwm_pkg::SEV_CRITICAL, kwm_pkg::SEV_CRITICAL,
        kwm_pkg::SEV_CRITICAL,
        kwm_pkg::SEV_HIGH, kwm_pkg::SEV_HIGH, kwm_pkg::SEV_HIGH, kwm_pkg::SEV_HIGH,
        kwm_pkg::SEV_HIGH, kwm_pkg::SEV_HIGH, kwm_pkg::SEV_HIGH,
        kwm_pkg::SEV_MEDIUM, kwm_pkg::SEV_MEDIUM, kwm_pkg::SEV_MEDIUM
    };

    // predictor state: folded bytes of the open text, [0] is the newest
    logic [7:0]    seen_bytes [kwm_pkg::HIST_DEPTH];
    kwm_pkg::sev_t open_sev;

    verdict_t   pending_verdicts [$];
    text_row_t  opening_rows [$];

    int  fail_count   = 0;
    int  verdicts_seen = 0;
    int  quiet_cycles = 0;
    bit  calm         = 1'b0;

    // free running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ascii upper case to lower case only
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // advance the predictor by one accepted word; closes the text on last
    task automatic scan_byte(input logic [7:0] raw, input logic last,
                             output bit closed, output kwm_pkg::sev_t sev);
        logic [7:0] win [kwm_pkg::WIN_LEN];
        int         k;
        int         j;
        int         len;
        bit         hit;
        win[0] = to_lower(raw);
        for (k = 0; k < kwm_pkg::HIST_DEPTH; k++)
        begin
            win[k + 1] = seen_bytes[k];
        end
        // every keyword is tested as ending on the current byte
        for (k = 0; k < kwm_pkg::KW_COUNT; k++)
        begin
            len = kw_word[k].len();
            hit = 1'b1;
            for (j = 0; j < len; j++)
            begin
                if (win[j] != kw_word[k][len - 1 - j])
                begin
                    hit = 1'b0;
                end
            end
            if (hit && kw_sev[k] > open_sev)
            begin
                open_sev = kw_sev[k];
            end
        end
        closed = last;
        sev    = open_sev;
        if (last)
        begin
            // a closed text leaves the window and the level as after reset
            for (k = 0; k < kwm_pkg::HIST_DEPTH; k++)
            begin
                seen_bytes[k] = 8'h00;
            end
            open_sev = kwm_pkg::SEV_LOW;
        end
        else
        begin
            for (k = kwm_pkg::HIST_DEPTH - 1; k > 0; k--)
            begin
                seen_bytes[k] = seen_bytes[k - 1];
            end
            seen_bytes[0] = win[0];
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last,
                            input bit typed, input kwm_pkg::sev_t sev);
        text_row_t row;
        row.text_byte = b;
        row.last_byte = last;
        row.typed     = typed;
        row.severity  = sev;
        opening_rows.push_back(row);
    endtask

    // whole text as rows, the last character carries the last mark
    task automatic add_text(input string s, input bit typed, input kwm_pkg::sev_t sev);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            add_byte(s[i], i == s.len() - 1, typed, sev);
        end
    endtask

    // offer one word, optionally after a gap, and wait for it to be taken;
    // returns at the edge that accepted it
    task automatic send_word(input logic [7:0] b, input logic last,
                             input int gap_pct, input bit typed,
                             input kwm_pkg::sev_t typed_sev);
        int            gap;
        bit            closed;
        kwm_pkg::sev_t sev;
        verdict_t      v;
        if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 19);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= last;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        scan_byte(b, last, closed, sev);
        if (closed)
        begin
            // hand-written rows take their typed level, others the predictor
            v.severity   = typed ? typed_sev : sev;
            v.alert_flag = (v.severity != kwm_pkg::SEV_LOW);
            pending_verdicts.push_back(v);
        end
    endtask

    // sender: directed table first, then random texts
    initial
    begin
        logic [7:0] text_q [$];
        string      s;
        logic [7:0] c;
        int         sent;
        int         target;
        int         gap_pct;
        int         k;
        int         j;
        int         len;
        int         pick;
        string      filler_chars;

        filler_chars = " abcxyzAPIXq./%=1-_:";
        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= 8'h00;
        text_ch.last_byte <= 1'b0;
        for (k = 0; k < kwm_pkg::HIST_DEPTH; k++)
        begin
            seen_bytes[k] = 8'h00;
        end
        open_sev = kwm_pkg::SEV_LOW;

        // one-byte texts at the byte extremes
        add_byte(8'h00, 1'b1, 1'b1, kwm_pkg::SEV_LOW);
        add_byte(8'hFF, 1'b1, 1'b1, kwm_pkg::SEV_LOW);
        // upper case folds onto the keyword
        add_text("SSH", 1'b1, kwm_pkg::SEV_HIGH);
        // a zero byte inside the text breaks the match
        add_byte("a", 1'b0, 1'b0, kwm_pkg::SEV_LOW);
        add_byte(8'h00, 1'b0, 1'b0, kwm_pkg::SEV_LOW);
        add_byte("p", 1'b0, 1'b0, kwm_pkg::SEV_LOW);
        add_byte("i", 1'b1, 1'b1, kwm_pkg::SEV_LOW);
        add_text("../", 1'b1, kwm_pkg::SEV_CRITICAL);
        // high bytes are not folded, so no 'a' comes out of 0xc1
        add_byte(8'hC1, 1'b0, 1'b0, kwm_pkg::SEV_LOW);
        add_text("PI", 1'b1, kwm_pkg::SEV_LOW);
        add_text("Admin", 1'b1, kwm_pkg::SEV_MEDIUM);
        // type, joining space, payload
        add_text("GET api", 1'b0, kwm_pkg::SEV_LOW);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_rows[i])
        begin
            send_word(opening_rows[i].text_byte, opening_rows[i].last_byte, 10,
                      opening_rows[i].typed, opening_rows[i].severity);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            text_q.delete();
            target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(3, 28);
            while (text_q.size() < target)
            begin
                pick = $urandom_range(0, 9);
                k    = $urandom_range(0, kwm_pkg::KW_COUNT - 1);
                s    = kw_word[k];
                if (pick <= 3)
                begin
                    // full keyword in random case
                    for (j = 0; j < s.len(); j++)
                    begin
                        c = s[j];
                        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                        begin
                            c = c - 8'h20;
                        end
                        text_q.push_back(c);
                    end
                end
                else if (pick == 4)
                begin
                    // keyword cut short
                    len = $urandom_range(1, s.len() - 1);
                    for (j = 0; j < len; j++)
                    begin
                        text_q.push_back(s[j]);
                    end
                end
                else if (pick == 5)
                begin
                    // keyword with one character spoiled
                    len = $urandom_range(0, s.len() - 1);
                    for (j = 0; j < s.len(); j++)
                    begin
                        text_q.push_back(j == len ? 8'($urandom_range(0, 255)) : s[j]);
                    end
                end
                else if (pick <= 7)
                begin
                    len = $urandom_range(1, 4);
                    for (j = 0; j < len; j++)
                    begin
                        text_q.push_back(filler_chars[$urandom_range(0,
                                         filler_chars.len() - 1)]);
                    end
                end
                else if (pick == 8)
                begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // zero, high bytes and the neighbors of the fold range
                    case ($urandom_range(0, 4))
                        0: c = 8'h00;
                        1: c = 8'h40;
                        2: c = 8'h5B;
                        3: c = 8'hC1;
                        default: c = 8'($urandom_range(128, 255));
                    endcase
                    text_q.push_back(c);
                end
            end

            // idling density changes from text to text, sometimes none
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 3;
                2: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            foreach (text_q[i])
            begin
                send_word(text_q[i], i == text_q.size() - 1, gap_pct, 1'b0,
                          kwm_pkg::SEV_LOW);
                sent++;
                if (sent >= CALM_FROM)
                begin
                    calm = 1'b1;
                end
            end
        end
        text_ch.valid <= 1'b0;

        // drain: the watchdog catches a result that never comes
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver: checks each result word and idles in bursts, with one
    // long hold-off that fills the output register and stalls the input
    initial
    begin
        verdict_t v;
        int       stall_left;
        int       stall_pct;
        bit       long_done;

        stall_left = 0;
        stall_pct  = 10;
        long_done  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                verdicts_seen++;
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected result word: severity %0d alert_flag %0d",
                           result_ch.severity, result_ch.alert_flag);
                    fail_count++;
                end
                else
                begin
                    v = pending_verdicts.pop_front();
                    if (result_ch.severity !== v.severity)
                    begin
                        $error("severity: expected %0d, actual %0d",
                               v.severity, result_ch.severity);
                        fail_count++;
                    end
                    if (result_ch.alert_flag !== v.alert_flag)
                    begin
                        $error("alert_flag: expected %0d, actual %0d",
                               v.alert_flag, result_ch.alert_flag);
                        fail_count++;
                    end
                end
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end

            if (!long_done && verdicts_seen == 30)
            begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
            end

            if (calm)
            begin
                stall_left = 0;
                result_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                // this cycle is the first of the burst
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word taken on either channel
    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
